// ----- hdl/plc_pkg.sv -----
// Shared types and constants for the positional list engine.
package plc_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_FIRST = 3'd0,
        OP_INSERT_LAST  = 3'd1,
        OP_INSERT_AT    = 3'd2,
        OP_DELETE_FIRST = 3'd3,
        OP_DELETE_LAST  = 3'd4,
        OP_DELETE_AT    = 3'd5,
        OP_DUMP         = 3'd6
    } t_plc_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_plc_status;

    // What every cell of the chain does while this mode is applied.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } t_cell_mode;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_plc_state;

endpackage

// ----- hdl/plc_cell.sv -----
// One storage cell of the list chain: holds one element and trades with its neighbors.
module plc_cell #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  logic                                  i_clk,
    input  plc_pkg::t_cell_mode                   i_mode,
    input  logic [$clog2(CAPACITY)-1:0]           i_idx,
    input  logic [$clog2(CAPACITY)-1:0]           i_last_idx,
    input  logic signed [plc_pkg::DATA_W-1:0]     i_ins_value,
    input  logic signed [plc_pkg::DATA_W-1:0]     i_left,
    input  logic signed [plc_pkg::DATA_W-1:0]     i_right,
    input  logic signed [plc_pkg::DATA_W-1:0]     i_head,
    output logic signed [plc_pkg::DATA_W-1:0]     o_value
);
    import plc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_mode)
            CM_INSERT: begin
                if (MY_IDX == i_idx) begin
                    n_value = i_ins_value;
                end else if (MY_IDX > i_idx) begin
                    n_value = i_left;
                end
            end
            CM_DELETE: begin
                if (MY_IDX >= i_idx) begin
                    n_value = i_right;
                end
            end
            CM_ROTATE: begin
                // The tail cell closes the ring by taking the front element.
                if (MY_IDX == i_last_idx) begin
                    n_value = i_head;
                end else begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- hdl/plc_chain.sv -----
// Row of list cells, front element in cell zero.
module plc_chain #(
    parameter int CAPACITY = 16
) (
    input  logic                                  i_clk,
    input  plc_pkg::t_cell_mode                   i_mode,
    input  logic [$clog2(CAPACITY)-1:0]           i_idx,
    input  logic [$clog2(CAPACITY)-1:0]           i_last_idx,
    input  logic signed [plc_pkg::DATA_W-1:0]     i_ins_value,
    output logic signed [plc_pkg::DATA_W-1:0]     o_head
);
    import plc_pkg::*;

    logic signed [DATA_W-1:0] w_val [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ins_value;
        end else begin : g_inner_left
            assign w_left = w_val[g-1];
        end

        // The tail cell has no right neighbor; what it takes there lies beyond the count.
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = i_ins_value;
        end else begin : g_inner_right
            assign w_right = w_val[g+1];
        end

        plc_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_mode      (i_mode),
            .i_idx       (i_idx),
            .i_last_idx  (i_last_idx),
            .i_ins_value (i_ins_value),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_head      (w_val[0]),
            .o_value     (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

// ----- hdl/positional_list_engine_top.sv -----
// Positional list engine: an ordered list of signed elements kept in a shifting cell chain.
//
// Inserts, deletes and unused operation codes are taken while busy is low and give one
// result in the following cycle, so such commands can be issued on every cycle while busy is low. A
// dump of a list of N elements keeps busy high while it runs and gives one result per
// cycle, front to back, with o_last_of_run on the last; the chain rotates one place a
// cycle to bring each element to the front and is back in order when the dump ends.
// A dump of an empty list gives a single result. Results appear for one cycle under
// o_result_valid and cannot be held off by the receiver.
module positional_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [plc_pkg::OP_W-1:0]                    i_operation,
    input  logic signed [plc_pkg::DATA_W-1:0]           i_value,
    input  logic [$clog2(CAPACITY+2)-1:0]               i_position,
    output logic                                        o_result_valid,
    output logic [plc_pkg::STAT_W-1:0]                  o_status,
    output logic [$clog2(CAPACITY+1)-1:0]               o_element_count,
    output logic signed [plc_pkg::DATA_W-1:0]           o_element_value,
    output logic                                        o_last_of_run
);
    import plc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY + 2);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    t_plc_state                r_state;
    t_plc_state                n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          r_dump_left;
    logic [CNT_W-1:0]          n_dump_left;
    logic                      r_valid;
    logic                      n_valid;
    logic [STAT_W-1:0]         r_status;
    logic [STAT_W-1:0]         n_status;
    logic signed [DATA_W-1:0]  r_value_out;
    logic signed [DATA_W-1:0]  n_value_out;
    logic                      r_last;
    logic                      n_last;

    t_cell_mode                w_mode;
    logic [IDX_W-1:0]          w_idx;
    logic [IDX_W-1:0]          w_last_idx;
    logic signed [DATA_W-1:0]  w_head;
    logic                      w_accept;
    logic [CMP_W-1:0]          w_pos_ext;
    logic [CMP_W-1:0]          w_cnt_ext;
    logic [POS_W-1:0]          w_pos_m1;

    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_pos_ext  = CMP_W'(i_position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_pos_m1   = i_position - POS_W'(1);
    assign w_last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dump_left = r_dump_left;
        n_valid     = 1'b0;
        n_status    = STAT_OK;
        n_value_out = '0;
        n_last      = 1'b1;
        w_mode      = CM_HOLD;
        w_idx       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    case (t_plc_op'(i_operation))
                        OP_INSERT_FIRST, OP_INSERT_LAST, OP_INSERT_AT: begin
                            if (w_cnt_ext >= CMP_W'(CAPACITY)) begin
                                n_status = STAT_FULL;
                            end else if (t_plc_op'(i_operation) == OP_INSERT_FIRST) begin
                                w_mode  = CM_INSERT;
                                w_idx   = '0;
                                n_count = r_count + CNT_W'(1);
                            end else if (t_plc_op'(i_operation) == OP_INSERT_LAST) begin
                                w_mode  = CM_INSERT;
                                w_idx   = IDX_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                            end else if (w_pos_ext == '0
                                         || w_pos_ext > w_cnt_ext + CMP_W'(1)) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                w_mode  = CM_INSERT;
                                w_idx   = IDX_W'(w_pos_m1);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE_FIRST, OP_DELETE_LAST, OP_DELETE_AT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else if (t_plc_op'(i_operation) == OP_DELETE_FIRST) begin
                                w_mode  = CM_DELETE;
                                w_idx   = '0;
                                n_count = r_count - CNT_W'(1);
                            end else if (t_plc_op'(i_operation) == OP_DELETE_LAST) begin
                                w_mode  = CM_DELETE;
                                w_idx   = w_last_idx;
                                n_count = r_count - CNT_W'(1);
                            end else if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                w_mode  = CM_DELETE;
                                w_idx   = IDX_W'(w_pos_m1);
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // Results come out of the dump state, one per element.
                                n_valid     = 1'b0;
                                n_state     = ST_DUMP;
                                n_dump_left = r_count;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                n_valid     = 1'b1;
                n_value_out = w_head;
                n_last      = (r_dump_left == CNT_W'(1));
                n_dump_left = r_dump_left - CNT_W'(1);
                w_mode      = CM_ROTATE;
                if (r_dump_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    plc_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk       (i_clk),
        .i_mode      (w_mode),
        .i_idx       (w_idx),
        .i_last_idx  (w_last_idx),
        .i_ins_value (i_value),
        .o_head      (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_left <= n_dump_left;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_value_out <= n_value_out;
        r_last      <= n_last;
    end

    assign busy            = (r_state == ST_DUMP);
    assign o_result_valid  = r_valid;
    assign o_status        = r_status;
    assign o_element_count = r_count;
    assign o_element_value = r_value_out;
    assign o_last_of_run   = r_last;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count exceeds capacity");

    a_dump_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_dump_left != '0 && r_dump_left <= r_count))
        else $error("dump counter out of step with element count");

    a_dump_ends_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && r_dump_left == CNT_W'(1))
            |=> (o_result_valid && o_last_of_run && !busy))
        else $error("dump did not end with a marked final result");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && t_plc_op'(i_operation) != OP_DUMP)
            |=> (o_result_valid && o_last_of_run))
        else $error("command did not give its single result");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the positional list engine, with a list predictor and scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int POS_W       = $clog2(CAPACITY + 2);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 300;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Command mix of one round of random traffic.
    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_EMPTY_OUT
    } t_mix;

    class list_scoreboard;
        typedef struct {
            t_plc_status              status;
            logic [CNT_W-1:0]         count;
            logic signed [DATA_W-1:0] value;
            logic                     last;
        } t_list_result;

        t_list_result             expected_q[$];
        logic signed [DATA_W-1:0] elems[CAPACITY];
        int                       count;
        int                       errors;
        int                       cmds_seen;
        int                       results_seen;
        int                       dumps;
        int                       full_hits;
        int                       empty_hits;
        int                       badpos_hits;

        function new();
            count        = 0;
            errors       = 0;
            cmds_seen    = 0;
            results_seen = 0;
            dumps        = 0;
            full_hits    = 0;
            empty_hits   = 0;
            badpos_hits  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(t_plc_status st, logic signed [DATA_W-1:0] v, logic last);
            t_list_result r;
            r.status = st;
            r.count  = count[CNT_W-1:0];
            r.value  = v;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        function void open_slot(int idx, logic signed [DATA_W-1:0] v);
            for (int i = count; i > idx; i--) begin
                elems[i] = elems[i-1];
            end
            elems[idx] = v;
            count++;
        endfunction

        function void close_slot(int idx);
            for (int i = idx; i + 1 < count; i++) begin
                elems[i] = elems[i+1];
            end
            count--;
        endfunction

        // Applies one accepted transaction to the predicted list and queues its results.
        function void note_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                               logic [POS_W-1:0] pos);
            t_plc_status st;
            int          p;
            st = STAT_OK;
            p  = int'(pos);
            cmds_seen++;
            case (op)
                OP_INSERT_FIRST, OP_INSERT_LAST, OP_INSERT_AT: begin
                    // A full list wins over a bad position.
                    if (count >= CAPACITY) st = STAT_FULL;
                    else if (op == OP_INSERT_FIRST) open_slot(0, v);
                    else if (op == OP_INSERT_LAST) open_slot(count, v);
                    else if (p < 1 || p > count + 1) st = STAT_BADPOS;
                    else open_slot(p - 1, v);
                end
                OP_DELETE_FIRST, OP_DELETE_LAST, OP_DELETE_AT: begin
                    if (count == 0) st = STAT_EMPTY;
                    else if (op == OP_DELETE_FIRST) close_slot(0);
                    else if (op == OP_DELETE_LAST) close_slot(count - 1);
                    else if (p < 1 || p > count) st = STAT_BADPOS;
                    else close_slot(p - 1);
                end
                OP_DUMP: begin
                    dumps++;
                    if (count == 0) begin
                        st = STAT_EMPTY;
                    end else begin
                        for (int i = 0; i < count; i++) begin
                            push_result(STAT_OK, elems[i], i == count - 1);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            if (st == STAT_FULL) full_hits++;
            if (st == STAT_EMPTY) empty_hits++;
            if (st == STAT_BADPOS) badpos_hits++;
            push_result(st, '0, 1'b1);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [CNT_W-1:0] c,
                                   logic signed [DATA_W-1:0] v, logic last);
            t_list_result e;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending: status %0d count %0d value %0d",
                       st, c, v);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (c !== e.count) begin
                $error("element_count: expected %0d, got %0d", e.count, c);
                errors++;
            end
            if (v !== e.value) begin
                $error("element_value: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_run: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          i_operation = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic                     o_result_valid;
    logic [STAT_W-1:0]        o_status;
    logic [CNT_W-1:0]         o_element_count;
    logic signed [DATA_W-1:0] o_element_value;
    logic                     o_last_of_run;

    list_scoreboard sb = new();
    int             cycle_count = 0;
    int             burst_left = 0;

    positional_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_element_count(o_element_count),
        .o_element_value(o_element_value),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_status, o_element_count, o_element_value, o_last_of_run);
        end
    end

    // Holds one command on the inputs until the block takes it.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                            input logic [POS_W-1:0] pos);
        i_operation <= op;
        i_value     <= v;
        i_position  <= pos;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(op, v, pos);
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Bursts of back-to-back commands separated by random gaps; some bursts run long.
    task automatic pace();
        if (burst_left == 0) begin
            idle($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
            else burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic random_cmd(input t_mix mix);
        int                       r;
        int                       kind;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         pos;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     kind = (r < 85) ? 0 : (r < 93) ? 2 : 1;
            MIX_EMPTY_OUT: kind = (r < 80) ? 1 : (r < 90) ? 2 : 0;
            default:      kind = (r < 10) ? 2 : (r < 54) ? 0 : (r < 98) ? 1 : 3;
        endcase
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            3: v = -1;
            default: v = $urandom;
        endcase
        pos = POS_W'($urandom_range(0, CAPACITY + 1));
        case (kind)
            0: begin
                case ($urandom_range(0, 2))
                    0: op = OP_INSERT_FIRST;
                    1: op = OP_INSERT_LAST;
                    default: begin
                        op = OP_INSERT_AT;
                        if ($urandom_range(0, 4) != 0)
                            pos = POS_W'($urandom_range(1, sb.count + 1));
                    end
                endcase
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: op = OP_DELETE_FIRST;
                    1: op = OP_DELETE_LAST;
                    default: begin
                        op = OP_DELETE_AT;
                        if (sb.count > 0 && $urandom_range(0, 4) != 0)
                            pos = POS_W'($urandom_range(1, sb.count));
                    end
                endcase
            end
            2: op = OP_DUMP;
            default: op = OP_UNUSED;
        endcase
        pace();
        send_cmd(op, v, pos);
    endtask

    initial begin
        int   round;
        int   n;
        t_mix mix;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-list cases, position limits, value extremes and the unused code.
        send_cmd(OP_DUMP, 0, 0);
        send_cmd(OP_DELETE_FIRST, 0, 0);
        send_cmd(OP_DELETE_LAST, 0, 0);
        send_cmd(OP_DELETE_AT, 0, 1);
        send_cmd(OP_INSERT_AT, 5, 0);
        send_cmd(OP_INSERT_AT, 6, 2);
        send_cmd(OP_INSERT_AT, VAL_MIN, 1);
        send_cmd(OP_INSERT_FIRST, VAL_MAX, 17);
        send_cmd(OP_INSERT_LAST, 0, 0);
        send_cmd(OP_INSERT_AT, 7, 5);
        send_cmd(OP_INSERT_AT, -1, 4);
        send_cmd(OP_DUMP, 0, 0);
        send_cmd(OP_DELETE_AT, 0, 0);
        send_cmd(OP_DELETE_AT, 0, 5);
        send_cmd(OP_DELETE_AT, 0, 2);
        send_cmd(OP_UNUSED, 32'sh5a5a_a5a5, 31);
        send_cmd(OP_DELETE_AT, 0, 3);
        send_cmd(OP_DELETE_FIRST, 0, 0);
        // The only element is removed here.
        send_cmd(OP_DELETE_LAST, 0, 0);
        send_cmd(OP_DUMP, 0, 0);
        send_cmd(OP_INSERT_AT, 9, 17);
        wait_all_results();

        n = sb.cmds_seen + RANDOM_CMDS;
        round = 0;
        while (sb.cmds_seen < n) begin
            mix = t_mix'(round % 3);
            case (mix)
                MIX_FILL: begin
                    while (sb.count < CAPACITY) random_cmd(mix);
                    repeat (4) random_cmd(mix);
                end
                MIX_EMPTY_OUT: begin
                    while (sb.count > 0) random_cmd(mix);
                    repeat (3) random_cmd(mix);
                end
                default: repeat ($urandom_range(10, 30)) random_cmd(mix);
            endcase
            if ($urandom_range(0, 2) == 0) wait_all_results();
            round++;
        end

        wait_all_results();
        idle(CAPACITY + 4);

        $display("Ran %0d commands in %0d rounds, including %0d dumps; checked %0d results.",
                 sb.cmds_seen, round, sb.dumps, sb.results_seen);
        $display("Rejected commands: %0d on a full list, %0d on an empty list, %0d bad positions.",
                 sb.full_hits, sb.empty_hits, sb.badpos_hits);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
